// File: rtl/xtl_pkg.sv
// Package for the XML tag lexer: character codes, lexer phase codes, event and
// error codes, tag kinds and the result record.
// No dependencies; every other file of the block but xtl_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package xtl_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 256;
	localparam int MAX_ATTRS_DEF     = 16;

	localparam int ATTR_IDX_W = 5;

	// Characters the lexer looks for.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Three-byte window contents.
	localparam logic [23:0] WIN_DOTS = 24'h2E2E2E;
	localparam logic [23:0] WIN_END  = 24'h2D2D3E;
	localparam logic [23:0] WIN_OPEN = 24'h212D2D;

	// Lexer phases.
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_NAME    = 4'd1;
	localparam logic [3:0] PH_CNAME   = 4'd2;
	localparam logic [3:0] PH_COMMENT = 4'd3;
	localparam logic [3:0] PH_CLOSE   = 4'd4;
	localparam logic [3:0] PH_KEY     = 4'd5;
	localparam logic [3:0] PH_VSTART  = 4'd6;
	localparam logic [3:0] PH_VDQ     = 4'd7;
	localparam logic [3:0] PH_VSQ     = 4'd8;
	localparam logic [3:0] PH_VBARE   = 4'd9;
	localparam logic [3:0] PH_VAFTER  = 4'd10;
	localparam logic [3:0] PH_SLASH   = 4'd11;
	localparam logic [3:0] PH_DONE    = 4'd12;
	localparam logic [3:0] PH_ERROR   = 4'd13;

	// Event kinds.
	localparam logic [2:0] EV_NAME    = 3'd0;
	localparam logic [2:0] EV_KEY     = 3'd1;
	localparam logic [2:0] EV_VALUE   = 3'd2;
	localparam logic [2:0] EV_COMMENT = 3'd3;
	localparam logic [2:0] EV_TAG_END = 3'd4;
	localparam logic [2:0] EV_DOC_END = 3'd5;
	localparam logic [2:0] EV_ERROR   = 3'd6;

	// Tag kinds.
	localparam logic [1:0] TAG_OPEN  = 2'd0;
	localparam logic [1:0] TAG_CLOSE = 2'd1;
	localparam logic [1:0] TAG_SELF  = 2'd2;

	// Error codes.
	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_NO_LT         = 4'd1;
	localparam logic [3:0] ERR_STRAY_EQ      = 4'd2;
	localparam logic [3:0] ERR_NAME_LONG     = 4'd3;
	localparam logic [3:0] ERR_NO_QUOTE      = 4'd4;
	localparam logic [3:0] ERR_CLOSE_TRAIL   = 4'd5;
	localparam logic [3:0] ERR_NO_GT         = 4'd6;
	localparam logic [3:0] ERR_COMMENT_OPEN  = 4'd7;
	localparam logic [3:0] ERR_EARLY_END     = 4'd8;
	localparam logic [3:0] ERR_VALUE_LONG    = 4'd9;

	typedef struct packed {
		logic [2:0]            event_kind;
		logic [7:0]            out_byte;
		logic                  first_of_field;
		logic [ATTR_IDX_W-1:0] attr_index;
		logic [1:0]            node_kind;
		logic [3:0]            error_code;
	} xtl_event_t;

endpackage

`default_nettype wire

// File: rtl/xtl_if.sv
// Handshake channels of the XML tag lexer: document text in, lexical events
// out, and the configuration write channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface xtl_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, in_byte, end_of_input, input ready);
	modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface xtl_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] out_byte;
	logic       first_of_field;
	logic [4:0] attr_index;
	logic [1:0] node_kind;
	logic [3:0] error_code;

	modport source (output valid, event_kind, out_byte, first_of_field, attr_index,
		node_kind, error_code, input ready);
	modport sink (input valid, event_kind, out_byte, first_of_field, attr_index,
		node_kind, error_code, output ready);
endinterface

interface xtl_cfg_if;
	logic valid;
	logic ready;
	logic allow_bare_integers;

	modport source (output valid, allow_bare_integers, input ready);
	modport sink (input valid, allow_bare_integers, output ready);
endinterface

`default_nettype wire

// File: rtl/xtl_fsm.sv
// Lexer state machine: holds the phase, token length, attribute count, comment
// window and tag kind, and turns one text byte into at most one event.
// Depends on xtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtl_fsm
	import xtl_pkg::*;
#(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int MAX_ATTRS     = MAX_ATTRS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] c,
	input  wire logic       eof,
	input  wire logic       allow_bare,
	output logic            emit,
	output xtl_event_t      evt
);

	localparam int FLEN_W = $clog2(MAX_TOKEN_LEN);
	localparam int ATTR_W = $clog2(MAX_ATTRS + 1);
	localparam logic [FLEN_W-1:0] FLEN_LIMIT = FLEN_W'(MAX_TOKEN_LEN - 1);
	localparam logic [FLEN_W-1:0] FLEN_TWO   = FLEN_W'(2);
	localparam logic [ATTR_W-1:0] ATTR_LIMIT = ATTR_W'(MAX_ATTRS);

	logic [3:0]        phase_q, phase_d;
	logic [FLEN_W-1:0] flen_q, flen_d;
	logic [ATTR_W-1:0] attr_q, attr_d;
	logic [23:0]       win_q, win_d;
	logic [1:0]        tag_q, tag_d;
	logic              name_empty_q, name_empty_d;

	logic [23:0]       win_sh;
	logic              is_ws;
	logic              is_term;
	logic              is_digit;
	logic              first;
	logic              after_tok;
	logic [1:0]        tag_eff;
	logic [ATTR_W+ATTR_IDX_W-1:0] attr_ext;
	logic [ATTR_IDX_W-1:0]        attr_idx;

	assign win_sh   = {win_q[15:0], c};
	assign is_ws    = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR);
	assign is_term  = is_ws || (c == CH_GT) || (c == CH_SLASH);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign first    = (flen_q == '0);
	assign attr_ext = {{ATTR_IDX_W{1'b0}}, attr_q};
	assign attr_idx = attr_ext[ATTR_IDX_W-1:0];

	always_comb begin
		phase_d      = phase_q;
		flen_d       = flen_q;
		attr_d       = attr_q;
		win_d        = win_q;
		tag_d        = tag_q;
		name_empty_d = name_empty_q;
		emit         = 1'b0;
		evt          = '0;
		after_tok    = 1'b0;
		tag_eff      = tag_q;

		if ((phase_q == PH_DONE) || (phase_q == PH_ERROR)) begin
			emit = 1'b0;
		end else if (phase_q == PH_IDLE) begin
			if (eof) begin
				phase_d        = PH_DONE;
				emit           = 1'b1;
				evt.event_kind = EV_DOC_END;
			end else if (!is_ws) begin
				if (c != CH_LT) begin
					phase_d        = PH_ERROR;
					emit           = 1'b1;
					evt.event_kind = EV_ERROR;
					evt.error_code = ERR_NO_LT;
				end else begin
					phase_d      = PH_NAME;
					flen_d       = '0;
					name_empty_d = 1'b1;
					attr_d       = '0;
					tag_d        = TAG_OPEN;
					win_d        = WIN_DOTS;
				end
			end
		end else if (eof) begin
			phase_d        = PH_ERROR;
			emit           = 1'b1;
			evt.event_kind = EV_ERROR;
			evt.error_code = (phase_q == PH_COMMENT) ? ERR_COMMENT_OPEN : ERR_EARLY_END;
		end else begin
			unique case (phase_q) inside
				PH_COMMENT: begin
					win_d = win_sh;
					if (win_sh == WIN_END) begin
						phase_d = PH_IDLE;
					end
				end
				PH_NAME, PH_CNAME, PH_CLOSE, PH_KEY, PH_SLASH: begin
					if (c == CH_EQ) begin
						if (phase_q != PH_KEY) begin
							phase_d        = PH_ERROR;
							emit           = 1'b1;
							evt.event_kind = EV_ERROR;
							evt.error_code = ERR_STRAY_EQ;
						end else begin
							phase_d = PH_VSTART;
							flen_d  = '0;
						end
					end else if (flen_q >= FLEN_LIMIT) begin
						phase_d        = PH_ERROR;
						emit           = 1'b1;
						evt.event_kind = EV_ERROR;
						evt.error_code = ERR_NAME_LONG;
					end else if (is_term) begin
						if (phase_q == PH_NAME) begin
							if (name_empty_q && (c == CH_SLASH)) begin
								tag_d   = TAG_CLOSE;
								phase_d = PH_CLOSE;
								flen_d  = '0;
							end else begin
								tag_d     = TAG_OPEN;
								tag_eff   = TAG_OPEN;
								after_tok = 1'b1;
							end
						end else if (phase_q == PH_CNAME) begin
							win_d   = win_sh;
							phase_d = (win_sh == WIN_END) ? PH_IDLE : PH_COMMENT;
						end else if (phase_q == PH_KEY) begin
							if (attr_q < ATTR_LIMIT) begin
								attr_d = attr_q + ATTR_W'(1);
							end
							after_tok = 1'b1;
						end else if (c == CH_GT) begin
							phase_d        = PH_IDLE;
							emit           = 1'b1;
							evt.event_kind = EV_TAG_END;
							evt.node_kind  = tag_q;
						end else begin
							phase_d        = PH_ERROR;
							emit           = 1'b1;
							evt.event_kind = EV_ERROR;
							evt.error_code = (phase_q == PH_CLOSE) ? ERR_CLOSE_TRAIL
								: ERR_NO_GT;
						end
					end else begin
						flen_d = flen_q + FLEN_W'(1);
						if (phase_q == PH_NAME) begin
							name_empty_d = 1'b0;
							win_d        = win_sh;
							// The third byte of "!--" turns the tag into a comment.
							if ((flen_q == FLEN_TWO) && (win_sh == WIN_OPEN)) begin
								phase_d        = PH_CNAME;
								win_d          = WIN_DOTS;
								emit           = 1'b1;
								evt.event_kind = EV_COMMENT;
							end else begin
								emit               = 1'b1;
								evt.event_kind     = EV_NAME;
								evt.out_byte       = c;
								evt.first_of_field = first;
							end
						end else if (phase_q == PH_CNAME) begin
							win_d = win_sh;
						end else if (phase_q == PH_CLOSE) begin
							emit               = 1'b1;
							evt.event_kind     = EV_NAME;
							evt.out_byte       = c;
							evt.first_of_field = first;
						end else if (phase_q == PH_KEY) begin
							emit               = 1'b1;
							evt.event_kind     = EV_KEY;
							evt.out_byte       = c;
							evt.first_of_field = first;
							evt.attr_index     = attr_idx;
						end
					end
				end
				PH_VSTART: begin
					if (c == CH_DQUOT) begin
						phase_d = PH_VDQ;
					end else if (c == CH_SQUOT) begin
						phase_d = PH_VSQ;
					end else if (!allow_bare) begin
						phase_d        = PH_ERROR;
						emit           = 1'b1;
						evt.event_kind = EV_ERROR;
						evt.error_code = ERR_NO_QUOTE;
					end else begin
						phase_d            = PH_VBARE;
						flen_d             = FLEN_W'(1);
						emit               = 1'b1;
						evt.event_kind     = EV_VALUE;
						evt.out_byte       = c;
						evt.first_of_field = 1'b1;
						evt.attr_index     = attr_idx;
					end
				end
				PH_VDQ, PH_VSQ: begin
					if (((phase_q == PH_VDQ) && (c == CH_DQUOT))
						|| ((phase_q == PH_VSQ) && (c == CH_SQUOT))) begin
						phase_d = PH_VAFTER;
					end else if (flen_q >= FLEN_LIMIT) begin
						phase_d        = PH_ERROR;
						emit           = 1'b1;
						evt.event_kind = EV_ERROR;
						evt.error_code = ERR_VALUE_LONG;
					end else begin
						flen_d             = flen_q + FLEN_W'(1);
						emit               = 1'b1;
						evt.event_kind     = EV_VALUE;
						evt.out_byte       = c;
						evt.first_of_field = first;
						evt.attr_index     = attr_idx;
					end
				end
				PH_VBARE, PH_VAFTER: begin
					if ((phase_q == PH_VBARE) && is_digit) begin
						if (flen_q >= FLEN_LIMIT) begin
							phase_d        = PH_ERROR;
							emit           = 1'b1;
							evt.event_kind = EV_ERROR;
							evt.error_code = ERR_VALUE_LONG;
						end else begin
							flen_d         = flen_q + FLEN_W'(1);
							emit           = 1'b1;
							evt.event_kind = EV_VALUE;
							evt.out_byte   = c;
							evt.attr_index = attr_idx;
						end
					end else begin
						if (attr_q < ATTR_LIMIT) begin
							attr_d = attr_q + ATTR_W'(1);
						end
						after_tok = 1'b1;
					end
				end
				default: begin
					phase_d        = PH_ERROR;
					emit           = 1'b1;
					evt.event_kind = EV_ERROR;
					evt.error_code = ERR_EARLY_END;
				end
			endcase
		end

		// A name or attribute has ended; the terminator decides what follows.
		if (after_tok) begin
			if (c == CH_SPACE) begin
				phase_d = PH_KEY;
				flen_d  = '0;
			end else if (c == CH_SLASH) begin
				tag_d   = TAG_SELF;
				phase_d = PH_SLASH;
				flen_d  = '0;
			end else if (c == CH_GT) begin
				phase_d        = PH_IDLE;
				emit           = 1'b1;
				evt.event_kind = EV_TAG_END;
				evt.node_kind  = tag_eff;
			end else begin
				phase_d        = PH_ERROR;
				emit           = 1'b1;
				evt.event_kind = EV_ERROR;
				evt.error_code = ERR_NO_GT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			flen_q       <= '0;
			attr_q       <= '0;
			win_q        <= WIN_DOTS;
			tag_q        <= TAG_OPEN;
			name_empty_q <= 1'b1;
		end else if (step) begin
			phase_q      <= phase_d;
			flen_q       <= flen_d;
			attr_q       <= attr_d;
			win_q        <= win_d;
			tag_q        <= tag_d;
			name_empty_q <= name_empty_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/xml_tag_lexer.sv
// Top level of the XML tag lexer: input register, lexer state machine, event
// output register and the configuration register.
// Depends on xtl_pkg, the channels in xtl_if and xtl_fsm.
`timescale 1ns / 1ps
`default_nettype none

// The lexer takes one byte of document text per request on the text channel and
// returns at most one event per byte on the events channel, in order. A byte is
// held in an input register, decoded by the lexer state machine when the output
// register is free or being emptied, and its event lands in that register; one
// byte can be taken every cycle as long as events are taken; a waiting
// event does not stop the input register from filling. The state machine's
// registers (phase, length, count, window, tag) are the only loop. After a
// document end or an error event the block takes bytes but reports nothing until
// reset. allow_bare_integers is written on the cfg channel, which is always
// ready, and should only be changed while no byte is in flight.
module xml_tag_lexer
	import xtl_pkg::*;
#(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int MAX_ATTRS     = MAX_ATTRS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	xtl_text_if.sink    text,
	xtl_event_if.source events,
	xtl_cfg_if.sink     cfg
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       advance;
	logic       emit;
	xtl_event_t evt;
	logic       valid_s2;
	xtl_event_t evt_s2;
	logic       allow_bare_q;

	assign advance    = valid_s1 && (!valid_s2 || events.ready);
	assign text.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
			eof_s1  <= text.end_of_input;
		end
	end

	xtl_fsm #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.MAX_ATTRS    (MAX_ATTRS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.c         (byte_s1),
		.eof       (eof_s1),
		.allow_bare(allow_bare_q),
		.emit      (emit),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (events.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			evt_s2 <= evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_bare_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			allow_bare_q <= cfg.allow_bare_integers;
		end
	end

	assign events.valid          = valid_s2;
	assign events.event_kind     = evt_s2.event_kind;
	assign events.out_byte       = evt_s2.out_byte;
	assign events.first_of_field = evt_s2.first_of_field;
	assign events.attr_index     = evt_s2.attr_index;
	assign events.node_kind      = evt_s2.node_kind;
	assign events.error_code     = evt_s2.error_code;

endmodule

`default_nettype wire

// File: rtl/xtl_checker.sv
// Port-level checks for the XML tag lexer and the bind that attaches them.
// Depends on xtl_pkg and the xml_tag_lexer top level.
`timescale 1ns / 1ps
`default_nettype none

module xtl_checker
	import xtl_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       ev_valid,
	input wire logic       ev_ready,
	input wire logic [2:0] ev_kind,
	input wire logic [7:0] ev_byte,
	input wire logic [3:0] ev_error
);

	// A stalled event stays offered unchanged.
	a_ev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(ev_kind) && $stable(ev_byte)
			&& $stable(ev_error))
		else $error("event changed while stalled");

	// Once the document end or an error has been delivered, nothing follows.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_ready && ((ev_kind == EV_ERROR) || (ev_kind == EV_DOC_END))
			|=> !ev_valid)
		else $error("event after the lexer stopped");

	// An error code is carried by error events and by nothing else.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ((ev_kind == EV_ERROR) == (ev_error != ERR_NONE)))
		else $error("error code does not match event kind");

endmodule

bind xml_tag_lexer xtl_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.ev_valid(events.valid),
	.ev_ready(events.ready),
	.ev_kind (events.event_kind),
	.ev_byte (events.out_byte),
	.ev_error(events.error_code)
);

`default_nettype wire

// File: tb/xtl_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the XML tag lexer: watches the text, event and cfg channels,
// predicts each event from the accepted text bytes and compares in order.
// Depends on xtl_pkg and the channel interfaces in xtl_if.

module xtl_event_checker
	import xtl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	xtl_text_if  text,
	xtl_event_if events,
	xtl_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	// Shadow copy of the lexer state.
	logic [3:0]  lex_state   = PH_IDLE;
	int          tok_len     = 0;
	logic [4:0]  n_attrs     = '0;
	logic [23:0] tail3       = WIN_DOTS;
	logic [1:0]  kind_now    = TAG_OPEN;
	logic        no_name_yet = 1'b1;
	logic        bare_ok     = 1'b0;

	xtl_event_t  due_events[$];
	int          fails = 0;

	function automatic xtl_event_t field_event(input logic [2:0] kind, input logic [7:0] c,
			input logic first, input logic [4:0] slot);
		xtl_event_t ev;
		ev = '0;
		ev.event_kind = kind;
		ev.out_byte = c;
		ev.first_of_field = first;
		ev.attr_index = slot;
		return ev;
	endfunction

	function automatic bit raise_error(input logic [3:0] code, output xtl_event_t ev);
		lex_state = PH_ERROR;
		ev = '0;
		ev.event_kind = EV_ERROR;
		ev.error_code = code;
		return 1'b1;
	endfunction

	function automatic bit close_tag(output xtl_event_t ev);
		lex_state = PH_IDLE;
		ev = '0;
		ev.event_kind = EV_TAG_END;
		ev.node_kind = kind_now;
		return 1'b1;
	endfunction

	// What follows a name, a key or a value: more attributes, a slash or the tag end.
	function automatic bit token_done(input logic [7:0] c, output xtl_event_t ev);
		ev = '0;
		if (c == CH_SPACE) begin
			lex_state = PH_KEY;
			tok_len = 0;
			return 1'b0;
		end
		if (c == CH_SLASH) begin
			kind_now = TAG_SELF;
			lex_state = PH_SLASH;
			tok_len = 0;
			return 1'b0;
		end
		if (c == CH_GT)
			return close_tag(ev);
		return raise_error(ERR_NO_GT, ev);
	endfunction

	function automatic bit attr_done(input logic [7:0] c, output xtl_event_t ev);
		if (n_attrs < MAX_ATTRS_DEF)
			n_attrs++;
		return token_done(c, ev);
	endfunction

	function automatic bit lex_byte(input logic [7:0] c, input logic eof, output xtl_event_t ev);
		logic first;
		ev = '0;
		if (lex_state == PH_DONE || lex_state == PH_ERROR)
			return 1'b0;
		if (lex_state == PH_IDLE) begin
			if (eof) begin
				lex_state = PH_DONE;
				ev.event_kind = EV_DOC_END;
				return 1'b1;
			end
			if (c == CH_SPACE || c == CH_LF || c == CH_CR)
				return 1'b0;
			if (c != CH_LT)
				return raise_error(ERR_NO_LT, ev);
			lex_state = PH_NAME;
			tok_len = 0;
			no_name_yet = 1'b1;
			n_attrs = '0;
			kind_now = TAG_OPEN;
			tail3 = WIN_DOTS;
			return 1'b0;
		end
		if (eof)
			return raise_error((lex_state == PH_COMMENT) ? ERR_COMMENT_OPEN : ERR_EARLY_END, ev);
		case (lex_state)
			PH_COMMENT: begin
				tail3 = {tail3[15:0], c};
				if (tail3 == WIN_END)
					lex_state = PH_IDLE;
				return 1'b0;
			end
			PH_NAME, PH_CNAME, PH_CLOSE, PH_KEY, PH_SLASH: begin
				if (c == CH_EQ) begin
					if (lex_state != PH_KEY)
						return raise_error(ERR_STRAY_EQ, ev);
					lex_state = PH_VSTART;
					tok_len = 0;
					return 1'b0;
				end
				// The terminator counts towards the length limit as well.
				if (tok_len >= MAX_TOKEN_LEN_DEF - 1)
					return raise_error(ERR_NAME_LONG, ev);
				if (c == CH_SPACE || c == CH_GT || c == CH_SLASH || c == CH_LF || c == CH_CR) begin
					case (lex_state)
						PH_NAME: begin
							if (no_name_yet && c == CH_SLASH) begin
								kind_now = TAG_CLOSE;
								lex_state = PH_CLOSE;
								tok_len = 0;
								return 1'b0;
							end
							kind_now = TAG_OPEN;
							return token_done(c, ev);
						end
						PH_CNAME: begin
							tail3 = {tail3[15:0], c};
							lex_state = (tail3 == WIN_END) ? PH_IDLE : PH_COMMENT;
							return 1'b0;
						end
						PH_CLOSE: begin
							if (c == CH_GT)
								return close_tag(ev);
							return raise_error(ERR_CLOSE_TRAIL, ev);
						end
						PH_KEY: return attr_done(c, ev);
						default: begin
							if (c == CH_GT)
								return close_tag(ev);
							return raise_error(ERR_NO_GT, ev);
						end
					endcase
				end
				first = (tok_len == 0);
				tok_len++;
				case (lex_state)
					PH_NAME: begin
						no_name_yet = 1'b0;
						tail3 = {tail3[15:0], c};
						// The third byte of a name starting with "!--" opens a comment.
						if (tok_len == 3 && tail3 == WIN_OPEN) begin
							lex_state = PH_CNAME;
							tail3 = WIN_DOTS;
							ev.event_kind = EV_COMMENT;
							return 1'b1;
						end
						ev = field_event(EV_NAME, c, first, '0);
						return 1'b1;
					end
					PH_CNAME: begin
						tail3 = {tail3[15:0], c};
						return 1'b0;
					end
					PH_CLOSE: begin
						ev = field_event(EV_NAME, c, first, '0);
						return 1'b1;
					end
					PH_KEY: begin
						ev = field_event(EV_KEY, c, first, n_attrs);
						return 1'b1;
					end
					default: return 1'b0;
				endcase
			end
			PH_VSTART: begin
				if (c == CH_DQUOT) begin
					lex_state = PH_VDQ;
					return 1'b0;
				end
				if (c == CH_SQUOT) begin
					lex_state = PH_VSQ;
					return 1'b0;
				end
				if (!bare_ok)
					return raise_error(ERR_NO_QUOTE, ev);
				lex_state = PH_VBARE;
				tok_len = 1;
				ev = field_event(EV_VALUE, c, 1'b1, n_attrs);
				return 1'b1;
			end
			PH_VDQ, PH_VSQ: begin
				if ((lex_state == PH_VDQ && c == CH_DQUOT) ||
						(lex_state == PH_VSQ && c == CH_SQUOT)) begin
					lex_state = PH_VAFTER;
					return 1'b0;
				end
				if (tok_len >= MAX_TOKEN_LEN_DEF - 1)
					return raise_error(ERR_VALUE_LONG, ev);
				first = (tok_len == 0);
				tok_len++;
				ev = field_event(EV_VALUE, c, first, n_attrs);
				return 1'b1;
			end
			PH_VBARE: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					if (tok_len >= MAX_TOKEN_LEN_DEF - 1)
						return raise_error(ERR_VALUE_LONG, ev);
					tok_len++;
					ev = field_event(EV_VALUE, c, 1'b0, n_attrs);
					return 1'b1;
				end
				return attr_done(c, ev);
			end
			PH_VAFTER: return attr_done(c, ev);
			default: return raise_error(ERR_EARLY_END, ev);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		xtl_event_t ev;
		xtl_event_t want;
		if (!arst_n) begin
			lex_state = PH_IDLE;
			tok_len = 0;
			n_attrs = '0;
			tail3 = WIN_DOTS;
			kind_now = TAG_OPEN;
			no_name_yet = 1'b1;
			bare_ok = 1'b0;
			due_events.delete();
			pending <= 0;
		end else begin
			if (events.valid && events.ready) begin
				if (due_events.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("lexer event with none expected: kind %0d byte %02h err %0d",
							events.event_kind, events.out_byte, events.error_code);
				end else begin
					want = due_events.pop_front();
					if (events.event_kind !== want.event_kind ||
							events.out_byte !== want.out_byte ||
							events.first_of_field !== want.first_of_field ||
							events.attr_index !== want.attr_index ||
							events.node_kind !== want.node_kind ||
							events.error_code !== want.error_code) begin
						fails++;
						if (fails <= 10) begin
							$display("lexer event mismatch, expected kind %0d byte %02h first %0b slot %0d node %0d err %0d",
								want.event_kind, want.out_byte, want.first_of_field,
								want.attr_index, want.node_kind, want.error_code);
							$display("  got kind %0d byte %02h first %0b slot %0d node %0d err %0d",
								events.event_kind, events.out_byte, events.first_of_field,
								events.attr_index, events.node_kind, events.error_code);
						end
					end
				end
			end
			if (text.valid && text.ready) begin
				if (lex_byte(text.in_byte, text.end_of_input, ev))
					due_events.push_back(ev);
			end
			if (cfg.valid && cfg.ready)
				bare_ok = cfg.allow_bare_integers;
			pending <= due_events.size();
		end
		fail_count <= fails;
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the XML tag lexer testbench: clock, reset, document text stimulus,
// event back-pressure and the verdict. Depends on xtl_pkg, xtl_if,
// xml_tag_lexer and xtl_event_checker.

module tb_top;
	import xtl_pkg::*;

	localparam int CYCLE_LIMIT = 20000;

	// Byte classes for random document text.
	localparam int PICK_NAME  = 0;
	localparam int PICK_KEY   = 1;
	localparam int PICK_DQ    = 2;
	localparam int PICK_SQ    = 3;
	localparam int PICK_BODY  = 4;
	localparam int PICK_DIGIT = 5;
	localparam int PICK_BARE  = 6;

	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_DASH = 8'h2D;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   bytes_fed = 0;
	int   cycle_count = 0;
	logic bare_on = 1'b0;

	xtl_text_if  text_ch ();
	xtl_event_if event_ch ();
	xtl_cfg_if   cfg_ch ();

	xml_tag_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.events (event_ch),
		.cfg    (cfg_ch)
	);

	xtl_event_checker event_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.events     (event_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		event_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bit is_delim(input logic [7:0] b);
		return b == CH_SPACE || b == CH_GT || b == CH_SLASH || b == CH_LF || b == CH_CR;
	endfunction

	function automatic logic [7:0] pick_byte(input int mode);
		logic [7:0] b;
		bit bad;
		if (mode == PICK_DIGIT)
			return 8'($urandom_range(CH_ZERO, CH_NINE));
		do begin
			b = 8'($urandom_range(0, 255));
			case (mode)
				// Names never start a comment by chance.
				PICK_NAME: bad = is_delim(b) || b == CH_EQ || b == CH_BANG;
				PICK_KEY:  bad = is_delim(b) || b == CH_EQ;
				PICK_DQ:   bad = b == CH_DQUOT;
				PICK_SQ:   bad = b == CH_SQUOT;
				PICK_BODY: bad = b == CH_DASH;
				default:   bad = b == CH_DQUOT || b == CH_SQUOT;
			endcase
		end while (bad);
		return b;
	endfunction

	// One text request; the sender may idle before it.
	task automatic feed(input logic [7:0] b, input logic eof);
		while ($urandom_range(0, 99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.end_of_input <= eof;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_fed++;
	endtask

	task automatic feed_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			feed(s[i], 1'b0);
	endtask

	task automatic send_run(input int mode, input int n);
		repeat (n) feed(pick_byte(mode), 1'b0);
	endtask

	// Waits until every predicted event has been taken and the pipeline is empty.
	task automatic settle();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_bare(input logic v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.allow_bare_integers <= v;
		bare_on = v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_tag();
		int r;
		int n_attr;
		feed(CH_LT, 1'b0);
		r = $urandom_range(0, 99);
		if (r < 20) begin
			feed(CH_SLASH, 1'b0);
			send_run(PICK_NAME, $urandom_range(0, 6));
			feed(CH_GT, 1'b0);
		end else if (r < 32) begin
			feed_str("!--");
			send_run(PICK_NAME, $urandom_range(0, 4));
			case ($urandom_range(0, 3))
				0: feed(CH_SPACE, 1'b0);
				1: feed(CH_LF, 1'b0);
				2: feed(CH_CR, 1'b0);
				default: feed(CH_SLASH, 1'b0);
			endcase
			send_run(PICK_BODY, $urandom_range(0, 10));
			feed_str("-->");
		end else begin
			send_run(PICK_NAME, $urandom_range(0, 6));
			n_attr = ($urandom_range(0, 19) == 0) ? MAX_ATTRS_DEF + 2 : $urandom_range(0, 4);
			repeat (n_attr) begin
				feed(CH_SPACE, 1'b0);
				send_run(PICK_KEY, $urandom_range(0, 5));
				if ($urandom_range(0, 3) != 0) begin
					feed(CH_EQ, 1'b0);
					if (bare_on && $urandom_range(0, 2) == 0) begin
						feed(pick_byte(PICK_BARE), 1'b0);
						send_run(PICK_DIGIT, $urandom_range(0, 4));
					end else if ($urandom_range(0, 1) == 0) begin
						feed(CH_DQUOT, 1'b0);
						send_run(PICK_DQ, $urandom_range(0, 8));
						feed(CH_DQUOT, 1'b0);
					end else begin
						feed(CH_SQUOT, 1'b0);
						send_run(PICK_SQ, $urandom_range(0, 8));
						feed(CH_SQUOT, 1'b0);
					end
				end
			end
			r = $urandom_range(0, 9);
			if (r < 6) begin
				feed(CH_GT, 1'b0);
			end else if (r < 9) begin
				feed_str("/>");
			end else begin
				feed(CH_SLASH, 1'b0);
				send_run(PICK_NAME, $urandom_range(1, 3));
				feed(CH_GT, 1'b0);
			end
		end
	endtask

	task automatic gen_document(input int budget);
		int start;
		start = bytes_fed;
		while (bytes_fed - start < budget) begin
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 2))
					0: feed(CH_SPACE, 1'b0);
					1: feed(CH_LF, 1'b0);
					default: feed(CH_CR, 1'b0);
				endcase
			end
			send_tag();
		end
	endtask

	// One name, key, quoted value or bare value at the longest length that is still
	// legal; the bare value needs allow_bare_integers set.
	task automatic send_long_fields();
		case ($urandom_range(0, 3))
			0: begin
				feed(CH_LT, 1'b0);
				send_run(PICK_NAME, MAX_TOKEN_LEN_DEF - 2);
				feed(CH_GT, 1'b0);
			end
			1: begin
				feed_str("<a ");
				send_run(PICK_KEY, MAX_TOKEN_LEN_DEF - 2);
				feed(CH_GT, 1'b0);
			end
			2: begin
				feed_str("<a k='");
				send_run(PICK_SQ, MAX_TOKEN_LEN_DEF - 1);
				feed_str("'>");
			end
			default: begin
				feed_str("<a n=");
				feed(pick_byte(PICK_BARE), 1'b0);
				send_run(PICK_DIGIT, MAX_TOKEN_LEN_DEF - 2);
				feed(CH_GT, 1'b0);
			end
		endcase
	endtask

	// Any error or the document end stops the lexer until reset, so a run can only
	// end one way; the seed picks which.
	task automatic finish_document(input logic [3:0] how);
		case (how)
			ERR_NONE:         feed(8'($urandom_range(0, 255)), 1'b1);
			ERR_NO_LT:        feed_str("x");
			ERR_STRAY_EQ:     feed_str("<=");
			ERR_NAME_LONG: begin
				feed(CH_LT, 1'b0);
				send_run(PICK_NAME, MAX_TOKEN_LEN_DEF);
			end
			ERR_NO_QUOTE:     feed_str("<a k=x");
			ERR_CLOSE_TRAIL:  feed_str("</a ");
			ERR_NO_GT:        feed_str("<a\n");
			ERR_COMMENT_OPEN: begin
				feed_str("<!-- x");
				feed(8'($urandom_range(0, 255)), 1'b1);
			end
			ERR_EARLY_END: begin
				feed_str("<a");
				feed(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				feed_str("<a k=\"");
				send_run(PICK_DQ, MAX_TOKEN_LEN_DEF);
			end
		endcase
		// The stopped lexer takes these requests and reports nothing.
		repeat (6) feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int p;
		logic [3:0] how;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.in_byte = '0;
		text_ch.end_of_input = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.allow_bare_integers = 1'b0;
		event_ch.ready = 1'b0;
		how = 4'($urandom_range(ERR_NONE, ERR_VALUE_LONG));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_bare(1'b0);
		feed_str(" \r\n<></a><");
		feed(8'h00, 1'b0);
		feed_str(" k v='");
		feed(8'hFF, 1'b0);
		feed_str("' w=\"\"/x>");
		feed_str("<!----><!-- z -->");
		settle();
		set_bare(1'b1);
		feed_str("<a n=7 m=x12 />");

		for (p = 0; p < 4; p++) begin
			settle();
			idle_pct = (p == 1) ? 71 : (p == 3) ? 6 : 0;
			stall_pct = (p == 2) ? 71 : (p == 3) ? 6 : 0;
			set_bare(p % 2 == 0);
			gen_document(28);
			// An over-long field at the end already runs a field up to its limit.
			if (p == 2 && how != ERR_NAME_LONG && how != ERR_VALUE_LONG)
				send_long_fields();
		end

		settle();
		if (how == ERR_NO_QUOTE)
			set_bare(1'b0);
		finish_document(how);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
